FILE: rtl/core/positional_list_engine_defines.svh
// ----------------------------------------------------------------------------
// positional list engine assertion macros
// shared concurrent assertion forms, clocked on clk_i with reset rst_ni
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// same-cycle implication
`define PLE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("positional list engine check failed");

// next-cycle implication
`define PLE_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("positional list engine check failed");

`endif

FILE: rtl/core/plen_pkg.sv
// ----------------------------------------------------------------------------
// positional list engine package
// field widths, request and status codes, and controller states
// ----------------------------------------------------------------------------
`default_nettype none

package plen_pkg;

  localparam int unsigned OP_W             = 3;
  localparam int unsigned POS_W            = 11;
  localparam int unsigned HANDLE_W         = 16;
  localparam int unsigned LEN_W            = 11;
  localparam int unsigned STATUS_W         = 2;
  localparam int unsigned DEFAULT_CAPACITY = 1024;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_BACK  = 3'd4,
    OP_REM_AT    = 3'd5,
    OP_READ_AT   = 3'd6
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_PUT,
    S_FETCH,
    S_REM_SHIFT
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/core/plen_req_if.sv
// ----------------------------------------------------------------------------
// positional list engine request channel
// valid/ready handshake carrying one list request per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface plen_req_if;
  import plen_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [POS_W-1:0]    position;
  logic [HANDLE_W-1:0] item_handle;

  modport source (output valid, output op, output position, output item_handle,
                  input ready);
  modport sink   (input valid, input op, input position, input item_handle,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/plen_rsp_if.sv
// ----------------------------------------------------------------------------
// positional list engine response channel
// valid/ready handshake carrying one result per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface plen_rsp_if;
  import plen_pkg::*;

  logic                valid;
  logic                ready;
  logic [HANDLE_W-1:0] out_handle;
  logic [LEN_W-1:0]    new_length;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output out_handle, output new_length, output status,
                  input ready);
  modport sink   (input valid, input out_handle, input new_length, input status,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional list engine
// ordered list of record handles with positional insert, remove and read
// ----------------------------------------------------------------------------
// The list lives in one synchronous memory of CAPACITY handles (one write
// port, one registered read port), slot 0 being the front. Requests are
// handled one at a time. Errors, the unused code and inserts at the back
// answer from the idle state; a read answers from the fetch state. A remove
// at position p and an insert at p below the length move every entry behind
// p by one slot through the single memory port pair, one entry per cycle.
// A new request is taken once the engine is idle and the result register is
// empty or being emptied. No clearing pass after reset.
`default_nettype none

module positional_list_engine #(
  parameter int unsigned CAPACITY = plen_pkg::DEFAULT_CAPACITY
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  plen_req_if.sink   req_i,
  plen_rsp_if.source rsp_o
);
  import plen_pkg::*;

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [HANDLE_W-1:0] mem_q [CAPACITY];
  logic [HANDLE_W-1:0] rd_data_q;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [HANDLE_W-1:0] wr_data;
  logic [AW-1:0]       rd_addr;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic [AW-1:0]       at_q, at_d;
  logic [HANDLE_W-1:0] item_q, item_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic                is_read_q, is_read_d;

  logic                out_valid_q, out_valid_d;
  logic [HANDLE_W-1:0] out_handle_q, out_handle_d;
  logic [LEN_W-1:0]    out_len_q, out_len_d;
  status_e             out_status_q, out_status_d;

  op_e                 op_sel;
  logic [AW-1:0]       at_sel;
  logic [CMP_W-1:0]    pos_ext;
  logic [CMP_W-1:0]    cnt_ext;
  logic [CNT_W-1:0]    cnt_inc;
  logic [CNT_W-1:0]    cnt_dec;
  logic [CMP_W-1:0]    inc_ext;
  logic [CMP_W-1:0]    dec_ext;
  logic [AW-1:0]       last_idx;
  logic                list_full;
  logic                list_empty;
  logic                req_ready;

  // request decode
  always_comb begin
    op_sel     = op_e'(req_i.op);
    pos_ext    = CMP_W'(req_i.position);
    cnt_ext    = CMP_W'(cnt_q);
    cnt_inc    = cnt_q + 1'b1;
    cnt_dec    = cnt_q - 1'b1;
    inc_ext    = CMP_W'(cnt_inc);
    dec_ext    = CMP_W'(cnt_dec);
    last_idx   = cnt_dec[AW-1:0];
    list_full  = (cnt_q == CNT_W'(CAPACITY));
    list_empty = (cnt_q == '0);
    case (op_sel)
      OP_INS_FRONT, OP_REM_FRONT: at_sel = '0;
      OP_INS_BACK:                at_sel = cnt_q[AW-1:0];
      OP_REM_BACK:                at_sel = last_idx;
      default:                    at_sel = pos_ext[AW-1:0];
    endcase
  end

  // controller
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    ptr_d        = ptr_q;
    at_d         = at_q;
    item_d       = item_q;
    handle_d     = handle_q;
    is_read_d    = is_read_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_handle_d = out_handle_q;
    out_len_d    = out_len_q;
    out_status_d = out_status_q;
    wr_en        = 1'b0;
    wr_addr      = ptr_q;
    wr_data      = rd_data_q;
    rd_addr      = ptr_q;
    req_ready    = 1'b0;

    case (state_q)
      S_IDLE: begin
        req_ready = !out_valid_q || rsp_o.ready;
        if (req_i.valid && req_ready) begin
          out_handle_d = '0;
          out_len_d    = cnt_ext[LEN_W-1:0];
          out_status_d = STATUS_OK;
          case (op_sel)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
              if (list_full) begin
                out_valid_d  = 1'b1;
                out_status_d = STATUS_FULL;
              end else if (op_sel == OP_INS_AT && pos_ext > cnt_ext) begin
                out_valid_d  = 1'b1;
                out_status_d = STATUS_RANGE;
              end else if (cnt_q == CNT_W'(at_sel)) begin
                // append: no entries to move
                wr_en       = 1'b1;
                wr_addr     = at_sel;
                wr_data     = req_i.item_handle;
                cnt_d       = cnt_inc;
                out_valid_d = 1'b1;
                out_len_d   = inc_ext[LEN_W-1:0];
              end else begin
                item_d  = req_i.item_handle;
                at_d    = at_sel;
                ptr_d   = last_idx;
                rd_addr = last_idx;
                state_d = S_INS_SHIFT;
              end
            end
            OP_REM_FRONT, OP_REM_BACK, OP_REM_AT, OP_READ_AT: begin
              if (list_empty) begin
                out_valid_d  = 1'b1;
                out_status_d = STATUS_EMPTY;
              end else if ((op_sel == OP_REM_AT || op_sel == OP_READ_AT) &&
                           pos_ext >= cnt_ext) begin
                out_valid_d  = 1'b1;
                out_status_d = STATUS_RANGE;
              end else begin
                at_d      = at_sel;
                rd_addr   = at_sel;
                is_read_d = (op_sel == OP_READ_AT);
                state_d   = S_FETCH;
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end

      S_INS_SHIFT: begin
        // move entry ptr up one slot, walking toward the insert point
        wr_en   = 1'b1;
        wr_addr = AW'(ptr_q + 1'b1);
        wr_data = rd_data_q;
        if (ptr_q == at_q) begin
          state_d = S_INS_PUT;
        end else begin
          ptr_d   = ptr_q - 1'b1;
          rd_addr = ptr_q - 1'b1;
        end
      end

      S_INS_PUT: begin
        wr_en        = 1'b1;
        wr_addr      = at_q;
        wr_data      = item_q;
        cnt_d        = cnt_inc;
        out_valid_d  = 1'b1;
        out_handle_d = '0;
        out_len_d    = inc_ext[LEN_W-1:0];
        out_status_d = STATUS_OK;
        state_d      = S_IDLE;
      end

      S_FETCH: begin
        handle_d     = rd_data_q;
        out_handle_d = rd_data_q;
        out_status_d = STATUS_OK;
        if (is_read_q) begin
          out_valid_d = 1'b1;
          out_len_d   = cnt_ext[LEN_W-1:0];
          state_d     = S_IDLE;
        end else if (at_q == last_idx) begin
          cnt_d       = cnt_dec;
          out_valid_d = 1'b1;
          out_len_d   = dec_ext[LEN_W-1:0];
          state_d     = S_IDLE;
        end else begin
          ptr_d   = AW'(at_q + 1'b1);
          rd_addr = AW'(at_q + 1'b1);
          state_d = S_REM_SHIFT;
        end
      end

      S_REM_SHIFT: begin
        // move entry ptr down one slot, closing the gap
        wr_en   = 1'b1;
        wr_addr = ptr_q - 1'b1;
        wr_data = rd_data_q;
        if (ptr_q == last_idx) begin
          cnt_d        = cnt_dec;
          out_valid_d  = 1'b1;
          out_handle_d = handle_q;
          out_len_d    = dec_ext[LEN_W-1:0];
          out_status_d = STATUS_OK;
          state_d      = S_IDLE;
        end else begin
          ptr_d   = AW'(ptr_q + 1'b1);
          rd_addr = AW'(ptr_q + 1'b1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // list memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    at_q         <= at_d;
    item_q       <= item_d;
    handle_q     <= handle_d;
    is_read_q    <= is_read_d;
    out_handle_q <= out_handle_d;
    out_len_q    <= out_len_d;
    out_status_q <= out_status_d;
  end

  assign req_i.ready      = req_ready;
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.out_handle = out_handle_q;
  assign rsp_o.new_length = out_len_q;
  assign rsp_o.status     = out_status_q;

endmodule

`default_nettype wire

FILE: rtl/core/plen_checker.sv
// ----------------------------------------------------------------------------
// positional list engine checker
// port-level assertions on the response channel, bound to positional_list_engine
// ----------------------------------------------------------------------------
`default_nettype none

`include "positional_list_engine_defines.svh"

module plen_checker #(
  parameter int unsigned CAPACITY = plen_pkg::DEFAULT_CAPACITY
) (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          rsp_valid_i,
  input wire                          rsp_ready_i,
  input wire [plen_pkg::HANDLE_W-1:0] rsp_handle_i,
  input wire [plen_pkg::LEN_W-1:0]    rsp_length_i,
  input wire [plen_pkg::STATUS_W-1:0] rsp_status_i
);
  import plen_pkg::*;

  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(CAPACITY);

  // stalled transaction holds its payload
  `PLE_ASSERT_NXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_handle_i) && $stable(rsp_length_i) && $stable(rsp_status_i))

  // empty report comes only from an empty list
  `PLE_ASSERT_IMP(a_empty_len, rsp_valid_i && rsp_status_i == STATUS_EMPTY, rsp_length_i == '0)

  // full report comes only from a full list
  `PLE_ASSERT_IMP(a_full_len, rsp_valid_i && rsp_status_i == STATUS_FULL, rsp_length_i == FULL_LEN)

  // failed requests return no handle
  `PLE_ASSERT_IMP(a_err_handle, rsp_valid_i && rsp_status_i != STATUS_OK, rsp_handle_i == '0)

endmodule

bind positional_list_engine plen_checker #(
  .CAPACITY(CAPACITY)
) u_plen_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_handle_i(rsp_o.out_handle),
  .rsp_length_i(rsp_o.new_length),
  .rsp_status_i(rsp_o.status)
);

`default_nettype wire
